### rtl/decimal_number_to_lcd_expander_bytes_macros.svh
// Assertion macros shared by the block's checker.
`ifndef DECIMAL_NUMBER_TO_LCD_EXPANDER_BYTES_MACROS_SVH
`define DECIMAL_NUMBER_TO_LCD_EXPANDER_BYTES_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define DNLCD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted while reset is high.
`define DNLCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define DNLCD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/dnlcd_pkg.sv
// Shared constants, types and helpers of the decimal-to-LCD expander byte block.
`timescale 1ns / 1ps

package dnlcd_pkg;

   // default sizes
   localparam int DEF_NUMBER_WIDTH = 16;
   localparam int DEF_MAX_DIGITS   = 5;

   // digit queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // character and byte formatting
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] HIGH_NIBBLE = 8'hF0;

   // control register map
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE_BITS   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENABLE_MASK = 1'b1;
   localparam logic [CSR_DATA_WIDTH-1:0]  MODE_BITS_RESET   = 4'd9;
   localparam logic [CSR_DATA_WIDTH-1:0]  ENABLE_MASK_RESET = 4'd4;

   // one digit to show, with a flag on the least significant one
   typedef struct packed {
      logic [3:0] digit;
      logic       last;
   } dnlcd_entry_type;

   // decimal digits needed for the largest value of a given bit width
   function automatic int decimal_digits(input int width);
      longint unsigned v;
      int              n;
      v = (64'd1 << width) - 64'd1;
      n = 0;
      for (int i = 0; i < 20; i++) begin
         if (v != 0) begin
            n = n + 1;
            v = v / 10;
         end
      end
      return n;
   endfunction

endpackage

### rtl/decimal_number_to_lcd_expander_bytes.sv
// Top level: number in, LCD port-expander byte run out, with control registers.
//
// Channel | Dir | Ports                                       | Beat
// req     | in  | req_tvalid, req_tready, req_tdata           | one number
// rsp     | out | rsp_tvalid, rsp_tready, rsp_tdata, rsp_tlast | one expander byte
// csr     | in  | csr_valid, csr_ready, csr_index, csr_data   | one register write
//
// The front takes a number when idle, converts it to BCD bit by bit and then
// queues the digits shown; it takes no new number before it is done.
// The back emits one byte a cycle unless the output stalls, six per digit;
// the slower of the two sets the rate.
// Reset is synchronous, active high; no clearing pass is needed.
// A stalled output holds its byte; the front stalls only when the queue fills.
`timescale 1ns / 1ps

module decimal_number_to_lcd_expander_bytes
   import dnlcd_pkg::*;
#(
   parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH,
   parameter int MAX_DIGITS   = DEF_MAX_DIGITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: number [NUMBER_WIDTH-1:0], zero padded to whole bytes
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]   req_tdata,
   // rsp_tdata: expander_byte [7:0]; rsp_tlast: last_of_run
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]          csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]           csr_data
);

   logic [CSR_DATA_WIDTH-1:0] mode_bits_ff;
   logic [CSR_DATA_WIDTH-1:0] enable_mask_ff;

   logic            push_valid;
   logic            push_ready;
   dnlcd_entry_type push_entry;
   logic            pop_valid;
   logic            pop_ready;
   dnlcd_entry_type pop_entry;

   // control registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_bits_ff   <= MODE_BITS_RESET;
         enable_mask_ff <= ENABLE_MASK_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MODE_BITS:   mode_bits_ff   <= csr_data;
            CSR_ENABLE_MASK: enable_mask_ff <= csr_data;
            default:         mode_bits_ff   <= mode_bits_ff;
         endcase
      end
   end

   dnlcd_front #(
      .NUMBER_WIDTH (NUMBER_WIDTH),
      .MAX_DIGITS   (MAX_DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_number  (req_tdata[NUMBER_WIDTH-1:0]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   dnlcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   dnlcd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (pop_entry),
      .mode_bits   (mode_bits_ff),
      .enable_mask (enable_mask_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule

### rtl/dnlcd_front.sv
// Front end: takes a number, converts it to BCD bit by bit, queues shown digits.
`timescale 1ns / 1ps

module dnlcd_front
   import dnlcd_pkg::*;
#(
   parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH,
   parameter int MAX_DIGITS   = DEF_MAX_DIGITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [NUMBER_WIDTH-1:0] in_number,
   output logic                    push_valid,
   input  logic                    push_ready,
   output dnlcd_entry_type         push_entry
);

   localparam int FULL_DIGITS = decimal_digits(NUMBER_WIDTH);
   localparam int BCD_DIGITS  = (FULL_DIGITS > MAX_DIGITS) ? FULL_DIGITS : MAX_DIGITS;
   localparam int BCD_BITS    = 4 * BCD_DIGITS;
   localparam int WIN_BITS    = 4 * MAX_DIGITS;
   localparam int BIT_CNT_W   = $clog2(NUMBER_WIDTH);
   localparam int DIG_CNT_W   = $clog2(MAX_DIGITS);
   localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(NUMBER_WIDTH - 1);
   localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(MAX_DIGITS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [NUMBER_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_BITS-1:0]     bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]    dig_cnt_ff, dig_cnt_in;
   logic                    started_ff, started_in;

   logic [BCD_BITS-1:0]     bcd_adj;
   logic [3:0]              top_digit;
   logic                    keep;
   logic                    advance;

   // add three to every digit of five or more before the shift
   always_comb begin
      bcd_adj = bcd_ff;
      for (int d = 0; d < BCD_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end
      end
   end

   // digit at the top of the shown window; leading zeros are skipped
   assign top_digit = bcd_ff[WIN_BITS-1 -: 4];
   assign keep      = started_ff || (top_digit != 4'd0) || (dig_cnt_ff == '0);
   assign advance   = (state_ff == ST_EMIT) && (!keep || push_ready);

   assign in_ready         = (state_ff == ST_IDLE);
   assign push_valid       = (state_ff == ST_EMIT) && keep;
   assign push_entry.digit = top_digit;
   assign push_entry.last  = (dig_cnt_ff == '0);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      started_in = started_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               bin_in     = in_number;
               bcd_in     = '0;
               bit_cnt_in = BIT_LAST;
               started_in = 1'b0;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in     = {bcd_adj[BCD_BITS-2:0], bin_ff[NUMBER_WIDTH-1]};
            bin_in     = bin_ff << 1;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               dig_cnt_in = DIG_LAST;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (advance) begin
               bcd_in     = bcd_ff << 4;
               dig_cnt_in = dig_cnt_ff - 1'b1;
               started_in = started_ff || keep;
               if (dig_cnt_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
   end

endmodule

### rtl/dnlcd_queue.sv
// Short digit queue that decouples the converter from the byte sequencer.
`timescale 1ns / 1ps

module dnlcd_queue
   import dnlcd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  dnlcd_entry_type push_entry,
   output logic            pop_valid,
   input  logic            pop_ready,
   output dnlcd_entry_type pop_entry
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   dnlcd_entry_type  slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/dnlcd_back.sv
// Back end: turns each queued digit into six expander bytes behind an output register.
`timescale 1ns / 1ps

module dnlcd_back
   import dnlcd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  dnlcd_entry_type           pop_entry,
   input  logic [CSR_DATA_WIDTH-1:0] mode_bits,
   input  logic [CSR_DATA_WIDTH-1:0] enable_mask,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [7:0]                out_byte,
   output logic                      out_last
);

   // strobe phases of one nibble
   localparam logic [1:0] PH_PLAIN  = 2'd0;
   localparam logic [1:0] PH_EN_SET = 2'd1;
   localparam logic [1:0] PH_EN_CLR = 2'd2;

   logic            cur_valid_ff, cur_valid_in;
   dnlcd_entry_type cur_ff;
   logic            nib_ff, nib_in;
   logic [1:0]      phase_ff, phase_in;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_byte_ff;
   logic            out_last_ff;

   logic            out_free;
   logic            advance;
   logic            final_beat;
   logic            load;
   logic [7:0]      ch;
   logic [3:0]      nib;
   logic [7:0]      base;
   logic [7:0]      en8;
   logic [7:0]      beat_byte;

   assign out_free   = !out_valid_ff || out_ready;
   assign advance    = cur_valid_ff && out_free;
   assign final_beat = nib_ff && (phase_ff == PH_EN_CLR);
   assign pop_ready  = !cur_valid_ff || (advance && final_beat);
   assign load       = pop_valid && pop_ready;

   // byte for the current nibble and phase
   assign ch   = ASCII_ZERO | {4'b0000, cur_ff.digit};
   assign nib  = nib_ff ? ch[3:0] : ch[7:4];
   assign base = ({nib, 4'b0000} & HIGH_NIBBLE) | {4'b0000, mode_bits};
   assign en8  = {4'b0000, enable_mask};

   always_comb begin
      case (phase_ff)
         PH_PLAIN:  beat_byte = base;
         PH_EN_SET: beat_byte = base | en8;
         default:   beat_byte = base & ~en8;
      endcase
   end

   // step through high then low nibble, three phases each
   always_comb begin
      cur_valid_in = cur_valid_ff;
      nib_in       = nib_ff;
      phase_in     = phase_ff;
      if (advance) begin
         if (phase_ff == PH_EN_CLR) begin
            phase_in = PH_PLAIN;
            nib_in   = !nib_ff;
         end else begin
            phase_in = phase_ff + 1'b1;
         end
         if (final_beat) begin
            cur_valid_in = 1'b0;
         end
      end
      if (load) begin
         cur_valid_in = 1'b1;
         nib_in       = 1'b0;
         phase_in     = PH_PLAIN;
      end
      out_valid_in = out_free ? cur_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         nib_ff       <= 1'b0;
         phase_ff     <= PH_PLAIN;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         nib_ff       <= nib_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= pop_entry;
      end
      if (advance) begin
         out_byte_ff <= beat_byte;
         out_last_ff <= final_beat && cur_ff.last;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;

endmodule

### rtl/dnlcd_checker.sv
// Port-level checker for the decimal-to-LCD expander byte block, with its bind.
`timescale 1ns / 1ps
`include "decimal_number_to_lcd_expander_bytes_macros.svh"

module dnlcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a stalled output beat keeps its byte and flag
   `DNLCD_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "rsp beat changed while stalled")

   // the front works on one number at a time
   `DNLCD_ASSERT_NEXT(a_req_one_at_a_time, clock, reset,
      req_tvalid && req_tready,
      !req_tready,
      "second number taken during conversion")

   // data nibble is always a decimal digit or the ASCII digit prefix
   `DNLCD_ASSERT_IMP(a_rsp_nibble, clock, reset,
      rsp_tvalid,
      rsp_tdata[7:4] <= 4'd9,
      "data nibble out of range")

   // no output beat right after reset
   `DNLCD_ASSERT_NEXT_ALWAYS(a_rsp_reset, clock,
      reset,
      !rsp_tvalid,
      "rsp valid after reset")

endmodule

bind decimal_number_to_lcd_expander_bytes dnlcd_checker u_dnlcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
